// ===== rtl/core/rtd_pkg.sv =====
// shared types and constants for the resource table dispatcher
`default_nettype none

package rtd_pkg;

    // default table depth
    localparam int SLOTS_DEF = 16;

    // field widths
    localparam int OP_W     = 2;
    localparam int CPU_W    = 16;
    localparam int MEM_W    = 22;
    localparam int IDENT_W  = 16;
    localparam int LINK_W   = 8;
    localparam int SLOT_O_W = 4;
    localparam int SCORE_W  = 10;

    // score = memory/8000 + cpu/1000
    // both divisors are 125 times a power of two: shift first, then divide by 125
    // via an exact reciprocal, ceil(2^23/125), good for any 16-bit dividend
    localparam int MEM_SHIFT   = 6;
    localparam int CPU_SHIFT   = 3;
    localparam int MUL_IN_W    = 16;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = 33;
    localparam logic [PROD_W-1:0] RECIP = PROD_W'(67109);

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_JOB_DONE = 2'd2,
        OP_DISPATCH = 2'd3
    } t_op;

    // reply kinds
    localparam logic REPLY_ADD      = 1'b0;
    localparam logic REPLY_DISPATCH = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_MEM,
        ST_MUL_CPU,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/resource_table_dispatcher.sv =====
// top level of the resource table dispatcher: table, scan sequencer and reply register
`default_nettype none

// Resource table dispatcher. Holds a table of SLOTS worker resources and takes one
// operation word at a time: add (store a resource in the lowest free slot with score
// memory/8000 + cpu/1000 and reply with a fresh identifier, or refuse when full),
// remove (free the lowest used slot with the given identifier), job done (set every
// busy slot with that identifier back to available) and dispatch (mark the available
// slot of strictly highest nonzero score busy, lowest slot on a tie, and reply with it).
// Add and dispatch produce one reply word, remove and job done produce none.
// Every operation runs a scan that reads the ident/score/link memory one slot per
// cycle through its single registered read port; add first computes the score, memory
// term then cpu term, through one shared multiplier. o_in_stall is high for the whole
// operation. The reply sits in an output register, so a new word is taken while the
// previous reply is still stalled; only the final write-back of add or dispatch waits
// for that register to free up. The table is empty after reset; no clearing
// pass is needed.

module resource_table_dispatcher #(
    parameter int SLOTS = rtd_pkg::SLOTS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // operation words
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire  [rtd_pkg::OP_W-1:0]      i_op,
    input  wire  [rtd_pkg::CPU_W-1:0]     i_cpu_speed,
    input  wire  [rtd_pkg::MEM_W-1:0]     i_memory_size,
    input  wire  [rtd_pkg::IDENT_W-1:0]   i_target_id,
    input  wire  [rtd_pkg::LINK_W-1:0]    i_link_tag,
    // reply words
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic                          o_reply_kind,
    output logic                          o_success,
    output logic [rtd_pkg::IDENT_W-1:0]   o_resource_id,
    output logic [rtd_pkg::SLOT_O_W-1:0]  o_slot_index,
    output logic [rtd_pkg::LINK_W-1:0]    o_chosen_link
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // sequencer
    rtd_pkg::t_state r_state, n_state;

    // captured operation word
    rtd_pkg::t_op                   r_op;
    logic [rtd_pkg::CPU_W-1:0]      r_cpu;
    logic [rtd_pkg::MEM_W-1:0]      r_mem;
    logic [rtd_pkg::IDENT_W-1:0]    r_target;
    logic [rtd_pkg::LINK_W-1:0]     r_link;

    // per-slot flags in flip-flops, cleared at reset
    logic [SLOTS-1:0]               r_used;
    logic [SLOTS-1:0]               r_busy;

    // slot payload memory, undefined until add writes it
    logic [rtd_pkg::IDENT_W-1:0]    r_mem_ident [SLOTS];
    logic [rtd_pkg::SCORE_W-1:0]    r_mem_score [SLOTS];
    logic [rtd_pkg::LINK_W-1:0]     r_mem_link  [SLOTS];
    logic [rtd_pkg::IDENT_W-1:0]    r_rd_ident;
    logic [rtd_pkg::SCORE_W-1:0]    r_rd_score;
    logic [rtd_pkg::LINK_W-1:0]     r_rd_link;

    logic [rtd_pkg::IDENT_W-1:0]    r_next_ident;

    // scan pipeline: issue counter, then check stage in the cycle after each issue
    logic [CNT_W-1:0]               r_rd_cnt;
    logic                           r_chk_vld;
    logic [IDX_W-1:0]               r_chk_idx;

    // scan result
    logic                           r_found;
    logic [IDX_W-1:0]               r_best_slot;
    logic [rtd_pkg::SCORE_W-1:0]    r_best_score;
    logic [rtd_pkg::IDENT_W-1:0]    r_best_ident;
    logic [rtd_pkg::LINK_W-1:0]     r_best_link;

    // score of a new resource
    logic [rtd_pkg::SCORE_W-1:0]    r_score;

    // reply register
    logic                           r_o_valid;
    logic                           r_o_kind;
    logic                           r_o_success;
    logic [rtd_pkg::IDENT_W-1:0]    r_o_id;
    logic [rtd_pkg::SLOT_O_W-1:0]   r_o_slot;
    logic [rtd_pkg::LINK_W-1:0]     r_o_link;

    // control from the sequencer
    logic                           in_take;
    logic                           out_free;
    logic                           out_load;
    logic                           commit;
    logic                           scan_done;
    logic                           rd_issue;
    logic [IDX_W-1:0]               rd_addr;

    // shared divide-by-125 multiplier
    logic [rtd_pkg::MUL_IN_W-1:0]   mul_in;
    logic [rtd_pkg::PROD_W-1:0]     mul_prod;
    logic [rtd_pkg::SCORE_W-1:0]    mul_quot;

    // per-slot checks in the scan
    logic                           chk_used;
    logic                           chk_busy;
    logic                           chk_match;
    logic                           hit_add;
    logic                           hit_remove;
    logic                           hit_done;
    logic                           hit_dispatch;

    assign in_take   = i_in_valid && !o_in_stall;
    assign out_free  = !r_o_valid || !i_out_stall;
    assign rd_issue  = (r_state == rtd_pkg::ST_SCAN) && (r_rd_cnt < CNT_W'(SLOTS));
    assign rd_addr   = r_rd_cnt[IDX_W-1:0];
    assign scan_done = (r_rd_cnt == CNT_W'(SLOTS)) && !r_chk_vld;

    // memory shifted down for add's first pass, cpu shifted down for the second
    assign mul_in   = (r_state == rtd_pkg::ST_MUL_MEM)
                    ? rtd_pkg::MUL_IN_W'(r_mem >> rtd_pkg::MEM_SHIFT)
                    : rtd_pkg::MUL_IN_W'(r_cpu >> rtd_pkg::CPU_SHIFT);
    assign mul_prod = rtd_pkg::PROD_W'(mul_in) * rtd_pkg::RECIP;
    assign mul_quot = mul_prod[rtd_pkg::RECIP_SHIFT +: rtd_pkg::SCORE_W];

    // check stage sees live flags, so earlier clears in this scan are visible
    assign chk_used     = r_used[r_chk_idx];
    assign chk_busy     = r_busy[r_chk_idx];
    assign chk_match    = (r_rd_ident == r_target);
    assign hit_add      = r_chk_vld && (r_op == rtd_pkg::OP_ADD) && !chk_used && !r_found;
    assign hit_remove   = r_chk_vld && (r_op == rtd_pkg::OP_REMOVE) && chk_used && chk_match
                        && !r_found;
    assign hit_done     = r_chk_vld && (r_op == rtd_pkg::OP_JOB_DONE) && chk_used
                        && chk_busy && chk_match;
    // strict compare against a best score starting at zero skips zero scores and ties
    assign hit_dispatch = r_chk_vld && (r_op == rtd_pkg::OP_DISPATCH) && chk_used
                        && !chk_busy && (r_rd_score > r_best_score);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and control
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            rtd_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (rtd_pkg::t_op'(i_op) == rtd_pkg::OP_ADD) begin
                        n_state = rtd_pkg::ST_MUL_MEM;
                    end else begin
                        n_state = rtd_pkg::ST_SCAN;
                    end
                end
            end
            rtd_pkg::ST_MUL_MEM: begin
                n_state = rtd_pkg::ST_MUL_CPU;
            end
            rtd_pkg::ST_MUL_CPU: begin
                n_state = rtd_pkg::ST_SCAN;
            end
            rtd_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = rtd_pkg::ST_FINISH;
                end
            end
            rtd_pkg::ST_FINISH: begin
                if (r_op == rtd_pkg::OP_ADD || r_op == rtd_pkg::OP_DISPATCH) begin
                    // write-back and reply go together once the reply register is free
                    if (out_free) begin
                        out_load = 1'b1;
                        commit   = r_found;
                        n_state  = rtd_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = rtd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rtd_pkg::ST_IDLE;
            end
        endcase
    end

    // operation capture and new-resource score
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op     <= rtd_pkg::t_op'(i_op);
            r_cpu    <= i_cpu_speed;
            r_mem    <= i_memory_size;
            r_target <= i_target_id;
            r_link   <= i_link_tag;
        end
        if (r_state == rtd_pkg::ST_MUL_MEM) begin
            r_score <= mul_quot;
        end else if (r_state == rtd_pkg::ST_MUL_CPU) begin
            r_score <= r_score + mul_quot;
        end
    end

    // slot payload memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (commit && r_op == rtd_pkg::OP_ADD) begin
            r_mem_ident[r_best_slot] <= r_next_ident;
            r_mem_score[r_best_slot] <= r_score;
            r_mem_link[r_best_slot]  <= r_link;
        end
        r_rd_ident <= r_mem_ident[rd_addr];
        r_rd_score <= r_mem_score[rd_addr];
        r_rd_link  <= r_mem_link[rd_addr];
    end

    // scan control and per-slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_busy       <= '0;
            r_next_ident <= '0;
            r_rd_cnt     <= '0;
            r_chk_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_best_score <= '0;
        end else begin
            if (in_take) begin
                r_rd_cnt     <= '0;
                r_chk_vld    <= 1'b0;
                r_found      <= 1'b0;
                r_best_score <= '0;
            end else if (r_state == rtd_pkg::ST_SCAN) begin
                r_chk_vld <= rd_issue;
                if (rd_issue) begin
                    r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                end
            end
            // remove frees the lowest match only
            if (hit_remove) begin
                r_used[r_chk_idx] <= 1'b0;
                r_busy[r_chk_idx] <= 1'b0;
            end
            // job done releases every busy match
            if (hit_done) begin
                r_busy[r_chk_idx] <= 1'b0;
            end
            if (hit_add || hit_remove || hit_dispatch) begin
                r_found <= 1'b1;
            end
            if (hit_dispatch) begin
                r_best_score <= r_rd_score;
            end
            if (commit) begin
                if (r_op == rtd_pkg::OP_ADD) begin
                    r_used[r_best_slot] <= 1'b1;
                    r_busy[r_best_slot] <= 1'b0;
                    r_next_ident        <= r_next_ident + rtd_pkg::IDENT_W'(1);
                end else begin
                    r_busy[r_best_slot] <= 1'b1;
                end
            end
        end
    end

    // scan datapath: check index and best candidate
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_chk_idx <= rd_addr;
        end
        if (in_take) begin
            r_best_slot  <= '0;
            r_best_ident <= '0;
            r_best_link  <= '0;
        end else if (hit_add || hit_dispatch) begin
            r_best_slot  <= r_chk_idx;
            r_best_ident <= r_rd_ident;
            r_best_link  <= r_rd_link;
        end
    end

    // reply register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_success <= r_found;
            if (r_op == rtd_pkg::OP_ADD) begin
                r_o_kind <= rtd_pkg::REPLY_ADD;
                r_o_id   <= r_found ? r_next_ident : '0;
                r_o_link <= '0;
            end else begin
                r_o_kind <= rtd_pkg::REPLY_DISPATCH;
                r_o_id   <= r_found ? r_best_ident : '0;
                r_o_link <= r_found ? r_best_link : '0;
            end
            r_o_slot <= r_found ? rtd_pkg::SLOT_O_W'(r_best_slot) : '0;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_reply_kind  = r_o_kind;
    assign o_success     = r_o_success;
    assign o_resource_id = r_o_id;
    assign o_slot_index  = r_o_slot;
    assign o_chosen_link = r_o_link;

    // a slot is never busy unless it is used
    a_busy_implies_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy & ~r_used) == '0)
        else $error("busy flag set on a free slot");

    // the block holds off new words right after taking one
    a_stall_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("input not stalled after acceptance");

    // check stage only runs during the scan
    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> (r_state == rtd_pkg::ST_SCAN))
        else $error("slot check outside scan");

    // a successful dispatch leaves its slot busy
    a_dispatch_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_op == rtd_pkg::OP_DISPATCH) |=> r_busy[$past(r_best_slot)])
        else $error("dispatched slot not marked busy");

    // a successful add leaves its slot used and available
    a_add_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_op == rtd_pkg::OP_ADD)
            |=> (r_used[$past(r_best_slot)] && !r_busy[$past(r_best_slot)]))
        else $error("added slot not marked used");

endmodule

`default_nettype wire
